/* hw/rtl/bpe_pkg.sv */
// ----------------------------------------------------------------------------
// Bicubic patch evaluator package
// Shared types and fixed constants for the patch evaluator controller,
// datapath and top level.
// ----------------------------------------------------------------------------
package bpe_pkg;

    // Fixed field and store geometry.
    localparam int PARAM_W     = 16;   // width of the u and v fields
    localparam int IDX_W       = 2;    // width of the row and column fields
    localparam int NUM_COMP    = 4;    // x, y, z, w
    localparam int NUM_ENTRIES = 16;   // 4 x 4 control grid
    localparam int ENTRY_W     = 4;    // {row, column}
    localparam int NUM_BASIS   = 8;    // four u terms, then four v terms
    localparam int BASIS_W     = 3;    // {v select, term}
    localparam int MAC_DRAIN   = 2;    // product and accumulate stages
    localparam int CNT_W       = 4;

    // Request codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Hermite basis terms in their fixed order.
    typedef enum logic [1:0] {
        TERM_H0 = 2'd0,   // (2t+1)(1-t)^2
        TERM_H1 = 2'd1,   // t(1-t)^2
        TERM_H2 = 2'd2,   // -t^2(1-t)
        TERM_H3 = 2'd3    // t^2(3-2t)
    } t_term;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASIS,
        ST_BWAIT,
        ST_MAC,
        ST_MWAIT,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               write_entry;
        logic               load_params;
        logic               basis_issue;
        logic [BASIS_W-1:0] basis_idx;
        logic               mac_issue;
        logic [ENTRY_W-1:0] entry;
        logic               finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic all_written;
    } t_dp_status;

endpackage

/* hw/rtl/bpe_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpe_ram #(
    parameter int  WIDTH  = 32,
    parameter int  DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/bpe_ctrl.sv */
// ----------------------------------------------------------------------------
// Bicubic patch evaluator controller
// Accepts requests and sequences the basis, accumulate and finish phases.
// ----------------------------------------------------------------------------
module bpe_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_cmd,
    output logic                o_busy,
    output bpe_pkg::t_dp_cmd    o_dp_cmd,
    input  bpe_pkg::t_dp_status i_status
);
    import bpe_pkg::*;

    localparam logic [CNT_W-1:0] BASIS_LAST = CNT_W'(NUM_BASIS - 1);
    localparam logic [CNT_W-1:0] MAC_LAST   = CNT_W'(NUM_ENTRIES - 1);
    localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(MAC_DRAIN - 1);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and phase counter.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && (i_cmd == CMD_EVAL) && i_status.all_written) begin
                    n_state = ST_BASIS;
                    n_cnt   = '0;
                end
            end
            ST_BASIS: begin
                if (r_cnt == BASIS_LAST) begin
                    n_state = ST_BWAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_BWAIT: begin
                n_state = ST_MAC;
            end
            ST_MAC: begin
                if (r_cnt == MAC_LAST) begin
                    n_state = ST_MWAIT;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_MWAIT: begin
                if (r_cnt == DRAIN_LAST) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_FINISH: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_dp_cmd = '0;
        o_busy   = (r_state != ST_IDLE);
        unique case (r_state)
            ST_IDLE: begin
                o_dp_cmd.write_entry = i_start && (i_cmd == CMD_WRITE);
                o_dp_cmd.load_params = i_start && (i_cmd == CMD_EVAL)
                                       && i_status.all_written;
            end
            ST_BASIS: begin
                o_dp_cmd.basis_issue = 1'b1;
                o_dp_cmd.basis_idx   = r_cnt[BASIS_W-1:0];
            end
            ST_MAC: begin
                o_dp_cmd.mac_issue = 1'b1;
                o_dp_cmd.entry     = r_cnt[ENTRY_W-1:0];
            end
            ST_FINISH: begin
                o_dp_cmd.finish = 1'b1;
            end
            default: begin
                o_dp_cmd = '0;
            end
        endcase
    end

    a_mac_needs_full_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.mac_issue |-> i_status.all_written)
        else $error("accumulation started on an incomplete control grid");

    a_load_starts_basis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_dp_cmd.load_params |=> (r_state == ST_BASIS))
        else $error("evaluate request did not start the basis phase");

    a_finish_returns_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |=> ((r_state == ST_IDLE) && !o_busy))
        else $error("controller did not return to idle after finishing");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_dp_cmd.write_entry, o_dp_cmd.load_params, o_dp_cmd.basis_issue,
                  o_dp_cmd.mac_issue, o_dp_cmd.finish}))
        else $error("more than one datapath command in a cycle");

endmodule

/* hw/rtl/bpe_datapath.sv */
// ----------------------------------------------------------------------------
// Bicubic patch evaluator datapath
// Control grid storage, Hermite basis unit, four multiply-accumulate lanes
// and the rounding and saturation stage.
// ----------------------------------------------------------------------------
module bpe_datapath #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bpe_pkg::t_dp_cmd              i_cmd,
    output bpe_pkg::t_dp_status           o_status,
    input  logic [bpe_pkg::IDX_W-1:0]     i_row_index,
    input  logic [bpe_pkg::IDX_W-1:0]     i_col_index,
    input  logic [COORD_WIDTH-1:0]        i_coord [bpe_pkg::NUM_COMP],
    input  logic [bpe_pkg::PARAM_W-1:0]   i_param_u,
    input  logic [bpe_pkg::PARAM_W-1:0]   i_param_v,
    output logic [COORD_WIDTH-1:0]        o_point [bpe_pkg::NUM_COMP],
    output logic                          o_saturated,
    output logic                          o_valid
);
    import bpe_pkg::*;

    localparam int F    = PARAM_FRAC_BITS;
    localparam int CW   = COORD_WIDTH;
    localparam int TW   = F + 1;                         // clamped parameter
    localparam int CMPW = (PARAM_W > TW) ? PARAM_W : TW;
    localparam int CCW  = F + 3;                         // basis coefficient
    localparam int BPPW = 2 * F + 1;                     // basis partial product
    localparam int BPW  = CCW + BPPW + 1;                // coefficient times partial
    localparam int HW   = F + 2;                         // basis value
    localparam int WW   = 2 * F + 2;                     // weight hu * hv
    localparam int PRW  = WW + CW;                       // weight times coordinate
    localparam int AW   = 2 * F + CW + 5;                // sixteen-term sum
    localparam int QW   = AW - 2 * F;                    // rounded sum

    localparam logic [CMPW-1:0]      S_CMP  = {{(CMPW-1){1'b0}}, 1'b1} << F;
    localparam logic [TW-1:0]        S_T    = {{(TW-1){1'b0}}, 1'b1} << F;
    localparam logic signed [BPW-1:0] B_HALF = {{(BPW-1){1'b0}}, 1'b1} << (2 * F - 1);
    localparam logic signed [AW-1:0]  A_HALF = {{(AW-1){1'b0}}, 1'b1} << (2 * F - 1);
    localparam logic [CW-1:0]        PT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        PT_MIN = {1'b1, {(CW-1){1'b0}}};

    // ---------------- control grid ----------------
    logic [NUM_ENTRIES-1:0] r_written;
    logic [ENTRY_W-1:0]     waddr;
    logic [CW-1:0]          rdata [NUM_COMP];

    assign waddr = {i_row_index, i_col_index};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_cmd.write_entry) begin
            r_written[waddr] <= 1'b1;
        end
    end

    assign o_status.all_written = &r_written;

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_store
        bpe_ram #(
            .WIDTH (CW),
            .DEPTH (NUM_ENTRIES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.write_entry),
            .i_waddr (waddr),
            .i_wdata (i_coord[c]),
            .i_raddr (i_cmd.entry),
            .o_rdata (rdata[c])
        );
    end

    // ---------------- parameter capture ----------------
    logic [TW-1:0]   r_t_u, r_t_v;
    logic [CMPW-1:0] u_ext, v_ext;

    assign u_ext = CMPW'(i_param_u);
    assign v_ext = CMPW'(i_param_v);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_params) begin
            r_t_u <= (u_ext > S_CMP) ? S_CMP[TW-1:0] : u_ext[TW-1:0];
            r_t_v <= (v_ext > S_CMP) ? S_CMP[TW-1:0] : v_ext[TW-1:0];
        end
    end

    // ---------------- basis unit, stage A ----------------
    logic [TW-1:0]    sa_t, sa_a, sa_x, sa_y;
    logic [CCW-1:0]   sa_tc, sa_sc, sa_c;
    logic [2*TW-1:0]  sa_p;

    always_comb begin
        sa_t  = i_cmd.basis_idx[BASIS_W-1] ? r_t_v : r_t_u;
        sa_a  = S_T - sa_t;
        sa_tc = CCW'(sa_t);
        sa_sc = CCW'(S_T);
        unique case (t_term'(i_cmd.basis_idx[1:0]))
            TERM_H0: begin
                sa_c = (sa_tc << 1) + sa_sc;
                sa_x = sa_a;
                sa_y = sa_a;
            end
            TERM_H1: begin
                sa_c = sa_tc;
                sa_x = sa_a;
                sa_y = sa_a;
            end
            TERM_H2: begin
                sa_c = '0 - sa_tc;
                sa_x = sa_t;
                sa_y = sa_a;
            end
            TERM_H3: begin
                sa_c = (sa_sc << 1) + sa_sc - (sa_tc << 1);
                sa_x = sa_t;
                sa_y = sa_t;
            end
            default: begin
                sa_c = '0;
                sa_x = '0;
                sa_y = '0;
            end
        endcase
        sa_p = (2*TW)'(sa_x) * (2*TW)'(sa_y);
    end

    logic                r_bvalid;
    logic [BASIS_W-1:0]  r_bidx;
    logic [CCW-1:0]      r_bc;
    logic [BPPW-1:0]     r_bp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvalid <= 1'b0;
        end else begin
            r_bvalid <= i_cmd.basis_issue;
        end
        r_bidx <= i_cmd.basis_idx;
        r_bc   <= sa_c;
        r_bp   <= sa_p[BPPW-1:0];   // the partial product never exceeds 2^(2F)
    end

    // ---------------- basis unit, stage B ----------------
    logic signed [BPW-1:0] sb_prod, sb_sum;
    logic signed [HW-1:0]  sb_h;
    logic signed [HW-1:0]  r_hu [4];
    logic signed [HW-1:0]  r_hv [4];

    assign sb_prod = BPW'($signed(r_bc)) * BPW'($signed({1'b0, r_bp}));
    assign sb_sum  = sb_prod + B_HALF;
    assign sb_h    = sb_sum[2*F+HW-1:2*F];

    always_ff @(posedge i_clk) begin
        if (r_bvalid) begin
            if (r_bidx[BASIS_W-1]) begin
                r_hv[r_bidx[1:0]] <= sb_h;
            end else begin
                r_hu[r_bidx[1:0]] <= sb_h;
            end
        end
    end

    // ---------------- weight and accumulate lanes ----------------
    logic signed [2*HW-1:0] mw_prod;
    logic signed [WW-1:0]   r_w;
    logic                   r_v1, r_v2;
    logic signed [PRW-1:0]  mp_prod [NUM_COMP];
    logic signed [PRW-1:0]  r_prod  [NUM_COMP];
    logic signed [AW-1:0]   r_acc   [NUM_COMP];

    // Row selects the u basis, column the v basis.
    assign mw_prod = (2*HW)'(r_hu[i_cmd.entry[ENTRY_W-1:IDX_W]])
                   * (2*HW)'(r_hv[i_cmd.entry[IDX_W-1:0]]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
        r_w <= mw_prod[WW-1:0];   // |hu * hv| never exceeds 2^(2F)
    end

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        assign mp_prod[c] = PRW'(r_w) * PRW'($signed(rdata[c]));

        always_ff @(posedge i_clk) begin
            r_prod[c] <= mp_prod[c];
            if (i_cmd.load_params) begin
                r_acc[c] <= '0;
            end else if (r_v2) begin
                r_acc[c] <= r_acc[c] + {{(AW-PRW){r_prod[c][PRW-1]}}, r_prod[c]};
            end
        end
    end

    // ---------------- round and saturate ----------------
    logic signed [AW-1:0] fin_sum [NUM_COMP];
    logic [QW-1:0]        fin_q   [NUM_COMP];
    logic [CW-1:0]        fin_pt  [NUM_COMP];
    logic [NUM_COMP-1:0]  fin_clip;

    always_comb begin
        for (int c = 0; c < NUM_COMP; c++) begin
            fin_sum[c]  = r_acc[c] + A_HALF;
            fin_q[c]    = fin_sum[c][AW-1:2*F];
            fin_clip[c] = !((&fin_q[c][QW-1:CW-1]) || !(|fin_q[c][QW-1:CW-1]));
            if (fin_clip[c]) begin
                fin_pt[c] = fin_q[c][QW-1] ? PT_MIN : PT_MAX;
            end else begin
                fin_pt[c] = fin_q[c][CW-1:0];
            end
        end
    end

    logic [CW-1:0] r_point [NUM_COMP];
    logic          r_sat;
    logic          r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.finish;
        end
        if (i_cmd.finish) begin
            r_point <= fin_pt;
            r_sat   <= |fin_clip;
        end
    end

    assign o_point     = r_point;
    assign o_saturated = r_sat;
    assign o_valid     = r_out_valid;

    a_drained_at_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_v1 && !r_v2 && !r_bvalid))
        else $error("result shown while the accumulate pipeline still held terms");

endmodule

/* hw/rtl/bicubic_patch_point_evaluator.sv */
// ----------------------------------------------------------------------------
// Bicubic Hermite patch point evaluator
// Holds a 4 x 4 grid of four-component control entries and evaluates
// points of the bicubic Hermite surface they define.
// ----------------------------------------------------------------------------
// Usage. A request is accepted on a rising edge where start is high and busy
// is low. With i_cmd at the write code it stores one control entry (x, y, z,
// w in signed Q16.16) at the given row and column; this produces no result
// and busy stays low, so writes can follow one per cycle. With i_cmd at the
// evaluate code it takes u and v (unsigned Q1.15, values above one act as
// one) and, once all sixteen entries have been written at least once,
// produces one point. An evaluate request that arrives before the grid is
// complete is dropped without a result.
// Sequence. An evaluate keeps busy high while it passes the shared basis unit
// (one Hermite term per cycle), a settle state, accumulation at one grid
// entry per cycle through four multiply-accumulate lanes, a drain of those
// lanes and a round-and-clamp state. The result is then registered on the
// o_point ports and marked by o_valid, high for a single cycle. Busy is low
// in that same cycle, so the next evaluate can be accepted there; a new one
// is not taken while the last is still in flight.
// The receiver cannot stall; it must take the result in its strobe cycle.
// Reset clears the written-entry mask, so the grid must be reloaded.
// ----------------------------------------------------------------------------
module bicubic_patch_point_evaluator #(
    parameter int COORD_WIDTH     = 32,
    parameter int PARAM_FRAC_BITS = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic [bpe_pkg::IDX_W-1:0]          i_row_index,
    input  logic [bpe_pkg::IDX_W-1:0]          i_col_index,
    input  logic signed [COORD_WIDTH-1:0]      i_coord_x,
    input  logic signed [COORD_WIDTH-1:0]      i_coord_y,
    input  logic signed [COORD_WIDTH-1:0]      i_coord_z,
    input  logic signed [COORD_WIDTH-1:0]      i_coord_w,
    input  logic [bpe_pkg::PARAM_W-1:0]        i_param_u,
    input  logic [bpe_pkg::PARAM_W-1:0]        i_param_v,
    output logic signed [COORD_WIDTH-1:0]      o_point_x,
    output logic signed [COORD_WIDTH-1:0]      o_point_y,
    output logic signed [COORD_WIDTH-1:0]      o_point_z,
    output logic signed [COORD_WIDTH-1:0]      o_point_w,
    output logic                               o_saturated,
    output logic                               o_valid
);
    import bpe_pkg::*;

    // Command and status between the sequencer and the datapath.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Components travel as a small array inside the block: x, y, z, w.
    logic [COORD_WIDTH-1:0] coord [NUM_COMP];
    logic [COORD_WIDTH-1:0] point [NUM_COMP];

    assign coord[0] = i_coord_x;
    assign coord[1] = i_coord_y;
    assign coord[2] = i_coord_z;
    assign coord[3] = i_coord_w;

    bpe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_cmd    (i_cmd),
        .o_busy   (busy),
        .o_dp_cmd (dp_cmd),
        .i_status (dp_status)
    );

    bpe_datapath #(
        .COORD_WIDTH     (COORD_WIDTH),
        .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_row_index (i_row_index),
        .i_col_index (i_col_index),
        .i_coord     (coord),
        .i_param_u   (i_param_u),
        .i_param_v   (i_param_v),
        .o_point     (point),
        .o_saturated (o_saturated),
        .o_valid     (o_valid)
    );

    assign o_point_x = point[0];
    assign o_point_y = point[1];
    assign o_point_z = point[2];
    assign o_point_w = point[3];

endmodule
